// File: sv/keyword_square_transpose_cipher_defines.svh
// Assertion macros for the keyword square transpose cipher.
// Included by the modules that check their own logic; depends on clk and rst_n in scope.
`ifndef KEYWORD_SQUARE_TRANSPOSE_CIPHER_DEFINES_SVH
`define KEYWORD_SQUARE_TRANSPOSE_CIPHER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define KWST_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("kwst check failed");

// The consequent must hold whenever the antecedent holds.
`define KWST_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kwst check failed");

`endif

// File: sv/kwst_pkg.sv
// Shared types, constants and helper functions of the keyword square transpose cipher.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package kwst_pkg;

    localparam int SquareSide  = 5;
    localparam int CellCount   = SquareSide * SquareSide;
    localparam int LetterCount = 26;
    localparam int IdxWidth    = $clog2(LetterCount);
    localparam int ReqWidth    = 2;
    localparam int CharWidth   = 8;

    localparam logic [IdxWidth-1:0] FullCount = IdxWidth'(CellCount);
    localparam logic [IdxWidth-1:0] LastCell  = IdxWidth'(CellCount - 1);
    localparam logic [IdxWidth-1:0] SideCount = IdxWidth'(SquareSide);

    localparam logic [CharWidth-1:0] UpperA = 8'h41;
    localparam logic [CharWidth-1:0] UpperZ = 8'h5A;
    localparam logic [CharWidth-1:0] LowerA = 8'h61;
    localparam logic [CharWidth-1:0] LowerZ = 8'h7A;

    typedef enum logic [ReqWidth-1:0] {
        REQ_KEY_LETTER = 2'd0,
        REQ_KEY_END    = 2'd1,
        REQ_ENCRYPT    = 2'd2,
        REQ_DECRYPT    = 2'd3
    } req_code_t;

    // Maps the cell of a letter at (row, col) to the cell at (col, row).
    function automatic logic [IdxWidth-1:0] transpose_cell(input logic [IdxWidth-1:0] pos);
        logic [IdxWidth-1:0] col;
        logic [IdxWidth-1:0] row;
        col = (pos >= FullCount) ? '0 : pos;
        row = '0;
        for (int i = 1; i < SquareSide; i++) begin
            if (col >= SideCount) begin
                col = col - SideCount;
                row = row + 1'b1;
            end
        end
        return IdxWidth'(col * SquareSide + row);
    endfunction

endpackage

`default_nettype wire

// File: sv/kwst_req_if.sv
// Request channel of the keyword square transpose cipher: request type and character.
// Depends on kwst_pkg for the field widths.
`default_nettype none

interface kwst_req_if
    import kwst_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ReqWidth-1:0]  req_type;
    logic [CharWidth-1:0] char_value;

    modport source (output valid, output req_type, output char_value, input ready);
    modport sink (input valid, input req_type, input char_value, output ready);
endinterface

`default_nettype wire

// File: sv/kwst_rsp_if.sv
// Result channel of the keyword square transpose cipher: one substituted or passed-through character.
// Depends on kwst_pkg for the field width.
`default_nettype none

interface kwst_rsp_if
    import kwst_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CharWidth-1:0] out_char;

    modport source (output valid, output out_char, input ready);
    modport sink (input valid, input out_char, output ready);
endinterface

`default_nettype wire

// File: sv/keyword_square_transpose_cipher.sv
// Top level of the keyword square transpose cipher: key square memories and lookup sequencer.
// Depends on kwst_pkg, kwst_req_if, kwst_rsp_if and keyword_square_transpose_cipher_defines.svh.
//
// The req channel carries one request at a time: a key letter, a key end, or a character
// to encrypt or decrypt. Key letters and key end produce no result; every text request
// produces exactly one character on the rsp channel, in request order.
// A key letter leaves req.ready high. A key end on a key that is not ready runs a fill
// sequence, one candidate letter per cycle, while req.ready stays low.
// A text request that hits a letter in the square reads the position memory and then the
// cell memory, each into a read register, before its result goes to the output register;
// req.ready stays low until the output register is written. A passthrough character skips
// both reads and goes straight to the output register.
// The output register holds the result until rsp.ready; the block keeps taking requests
// while it waits, but a text request taken then holds req.ready low until the waiting
// result is taken.
// Reset clears the key: no letters present, an empty fill count, key not ready, and no
// pending result. The square memories are not cleared and are only read after a write.
`default_nettype none

`include "keyword_square_transpose_cipher_defines.svh"

module keyword_square_transpose_cipher
    import kwst_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    kwst_req_if.sink    req,
    kwst_rsp_if.source  rsp
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FILL   = 4'b0010,
        ST_POS    = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t                   state_reg, state_next;
    logic [IdxWidth-1:0]      fill_count_reg, fill_count_next;
    logic                     key_ready_reg, key_ready_next;
    logic [LetterCount-1:0]   present_reg, present_next;
    logic [IdxWidth-1:0]      fill_idx_reg, fill_idx_next;
    logic [CharWidth-1:0]     char_reg, char_next;
    logic                     hit_reg, hit_next;
    logic                     enc_reg, enc_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CharWidth-1:0]     out_char_reg, out_char_next;

    logic [IdxWidth-1:0]      cells_mem [CellCount];
    logic [IdxWidth-1:0]      pos_mem [LetterCount];
    logic                     wr_en;
    logic [IdxWidth-1:0]      wr_cell;
    logic [IdxWidth-1:0]      wr_letter;
    logic                     pos_rd_en;
    logic [IdxWidth-1:0]      pos_rd_addr;
    logic [IdxWidth-1:0]      pos_rdata_reg;
    logic                     cell_rd_en;
    logic [IdxWidth-1:0]      cell_rd_addr;
    logic [IdxWidth-1:0]      cell_rdata_reg;

    logic                     accept;
    logic                     out_free;
    logic                     is_upper;
    logic                     is_lower;
    logic [CharWidth-1:0]     upper_diff;
    logic [CharWidth-1:0]     lower_diff;
    logic [IdxWidth-1:0]      upper_idx;
    logic [IdxWidth-1:0]      lower_idx;
    logic [IdxWidth-1:0]      text_idx;
    logic                     text_hit;
    logic [LetterCount-1:0]   base_present;
    logic [IdxWidth-1:0]      base_fill;
    logic [CharWidth-1:0]     case_base;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign rsp.valid    = out_valid_reg;
    assign rsp.out_char = out_char_reg;

    assign is_upper   = req.char_value inside {[UpperA:UpperZ]};
    assign is_lower   = req.char_value inside {[LowerA:LowerZ]};
    assign upper_diff = req.char_value - UpperA;
    assign lower_diff = req.char_value - LowerA;
    assign upper_idx  = upper_diff[IdxWidth-1:0];
    assign lower_idx  = lower_diff[IdxWidth-1:0];
    assign text_idx   = (req.req_type == REQ_ENCRYPT) ? lower_idx : upper_idx;
    assign text_hit   = key_ready_reg && present_reg[text_idx]
                        && ((req.req_type == REQ_ENCRYPT) ? is_lower : is_upper);
    assign base_present = key_ready_reg ? '0 : present_reg;
    assign base_fill    = key_ready_reg ? '0 : fill_count_reg;
    assign case_base    = enc_reg ? UpperA : LowerA;

    always_comb begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        key_ready_next  = key_ready_reg;
        present_next    = present_reg;
        fill_idx_next   = fill_idx_reg;
        char_next       = char_reg;
        hit_next        = hit_reg;
        enc_next        = enc_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_char_next   = out_char_reg;
        wr_en           = 1'b0;
        wr_cell         = fill_count_reg;
        wr_letter       = fill_idx_reg;
        pos_rd_en       = 1'b0;
        pos_rd_addr     = text_idx;
        cell_rd_en      = 1'b0;
        cell_rd_addr    = transpose_cell(pos_rdata_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    case (req.req_type)
                        REQ_KEY_LETTER:
                        begin
                            if (is_upper) begin
                                key_ready_next  = 1'b0;
                                present_next    = base_present;
                                fill_count_next = base_fill;
                                if (base_fill < FullCount && !base_present[upper_idx]) begin
                                    wr_en                   = 1'b1;
                                    wr_cell                 = base_fill;
                                    wr_letter               = upper_idx;
                                    present_next[upper_idx] = 1'b1;
                                    fill_count_next         = base_fill + 1'b1;
                                end
                            end
                        end
                        REQ_KEY_END:
                        begin
                            if (!key_ready_reg) begin
                                fill_idx_next = '0;
                                state_next    = ST_FILL;
                            end
                        end
                        REQ_ENCRYPT, REQ_DECRYPT:
                        begin
                            char_next = req.char_value;
                            enc_next  = (req.req_type == REQ_ENCRYPT);
                            hit_next  = text_hit;
                            if (text_hit) begin
                                pos_rd_en  = 1'b1;
                                state_next = ST_POS;
                            end else begin
                                state_next = ST_RESULT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                if (fill_count_reg < FullCount && !present_reg[fill_idx_reg]) begin
                    wr_en                      = 1'b1;
                    present_next[fill_idx_reg] = 1'b1;
                    fill_count_next            = fill_count_reg + 1'b1;
                end
                if (fill_idx_reg == LastCell) begin
                    key_ready_next = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    fill_idx_next = fill_idx_reg + 1'b1;
                end
            end
            ST_POS:
            begin
                cell_rd_en = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = hit_reg ? (case_base + {3'b000, cell_rdata_reg})
                                             : char_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            key_ready_reg  <= 1'b0;
            present_reg    <= '0;
            fill_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            key_ready_reg  <= key_ready_next;
            present_reg    <= present_next;
            fill_idx_reg   <= fill_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        char_reg     <= char_next;
        hit_reg      <= hit_next;
        enc_reg      <= enc_next;
        out_char_reg <= out_char_next;
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            cells_mem[wr_cell] <= wr_letter;
            pos_mem[wr_letter] <= wr_cell;
        end
    end

    always_ff @(posedge clk) begin
        if (pos_rd_en) begin
            pos_rdata_reg <= pos_mem[pos_rd_addr];
        end
    end

    always_ff @(posedge clk) begin
        if (cell_rd_en) begin
            cell_rdata_reg <= cells_mem[cell_rd_addr];
        end
    end

    `KWST_ASSERT_ALWAYS(a_present_matches_fill, $countones(present_reg) == int'(fill_count_reg))
    `KWST_ASSERT_IMPLIES(a_ready_square_full, key_ready_reg, fill_count_reg == FullCount)
    `KWST_ASSERT_IMPLIES(a_ready_after_fill, $rose(key_ready_reg), $past(state_reg) == ST_FILL)

endmodule

`default_nettype wire
